// ===== rtl/core/utf16d_pkg.sv =====
// Shared types, constants and helpers of the UTF-16 stream decoder.
package utf16d_pkg;

  // Byte order selector codes; the unused code acts as big endian
  localparam logic [1:0] ORDER_AUTO   = 2'd0;
  localparam logic [1:0] ORDER_BIG    = 2'd1;
  localparam logic [1:0] ORDER_LITTLE = 2'd2;

  // Byte order mark bytes
  localparam logic [7:0] MARK_FE = 8'hFE;
  localparam logic [7:0] MARK_FF = 8'hFF;

  // High byte bounds of a surrogate unit (exclusive)
  localparam logic [7:0] SURR_BELOW = 8'hD7;
  localparam logic [7:0] SURR_ABOVE = 8'hE0;

  // Surrogate pair combination constants
  localparam logic [31:0] HI_BASE     = 32'h0000_D800;
  localparam logic [31:0] LO_BASE     = 32'h0000_DC00;
  localparam logic [31:0] PAIR_OFFSET = 32'h0001_0000;

  localparam logic [1:0] CNT_NONE  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // Per-stream decode state
  typedef struct packed {
    logic [7:0] held0;
    logic [7:0] held1;
    logic [7:0] held2;
    logic [1:0] held_count;
    logic       pair_expected;
    logic       at_stream_start;
    logic       swap_bytes;
  } dec_state_t;

  // One decoded result beat
  typedef struct packed {
    logic [31:0] char_code;
    logic        stream_end;
  } result_t;

  localparam dec_state_t STATE_CLEAR = '{
    held0: 8'h00, held1: 8'h00, held2: 8'h00, held_count: CNT_NONE,
    pair_expected: 1'b0, at_stream_start: 1'b1, swap_bytes: 1'b0
  };

  // Assemble a 16-bit code unit from two bytes in stream order
  function automatic logic [15:0] unit_of(input logic [7:0] first,
                                          input logic [7:0] second,
                                          input logic       le);
    unit_of = le ? {second, first} : {first, second};
  endfunction

endpackage

// ===== rtl/core/utf16_stream_decoder.sv =====
// Top level of the UTF-16 stream decoder: byte input, code point output.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------
//   input    | in_valid / in_stall  | data_byte, last_byte
//   output   | out_valid / out_stall| char_code, stream_end
//   config   | cfg_write            | cfg_data (byte_order)
//
// One byte is taken every cycle while in_stall is low; a result is registered in
// the output register, or in the skid stage when the output is stalled. State
// updates at the byte beat through one level of decode logic. Reset clears the
// stream state and sets byte_order to auto. in_stall rises only while the skid
// stage holds a beat behind a stalled output register.
module utf16_stream_decoder import utf16d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] char_code,
  output logic        stream_end
);

  logic [1:0] byte_order;
  dec_state_t state;
  dec_state_t state_next;
  logic       have;
  result_t    result;
  logic       accept;
  logic       full;
  result_t    out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Hold the byte order selector
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= ORDER_AUTO;
    end else if (cfg_write) begin
      byte_order <= cfg_data;
    end
  end

  // Advance the stream state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  utf16d_step u_step (
    .state      (state),
    .byte_order (byte_order),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .state_next (state_next),
    .have       (have),
    .result     (result)
  );

  utf16d_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && have),
    .load_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign char_code  = out_data.char_code;
  assign stream_end = out_data.stream_end;

endmodule

// ===== rtl/core/utf16d_step.sv =====
// Next-state and result logic for one stream byte of the UTF-16 decoder.
module utf16d_step import utf16d_pkg::*; (
  input  dec_state_t state,
  input  logic [1:0] byte_order,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output dec_state_t state_next,
  output logic       have,
  output result_t    result
);

  logic        le_now;
  logic        le_unit;
  logic        mark;
  logic        mark_le;
  logic [7:0]  high;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;
  logic [31:0] hi_off;
  logic [31:0] lo_off;
  logic [31:0] cp;

  assign le_now = (byte_order == ORDER_LITTLE) || ((byte_order == ORDER_AUTO) && state.swap_bytes);

  // Byte order mark detection on the first unit in auto mode
  always_comb begin
    mark    = 1'b0;
    mark_le = 1'b0;
    if ((byte_order == ORDER_AUTO) && state.at_stream_start) begin
      if ((state.held0 == MARK_FE) && (data_byte == MARK_FF)) begin
        mark = 1'b1;
      end else if ((state.held0 == MARK_FF) && (data_byte == MARK_FE)) begin
        mark    = 1'b1;
        mark_le = 1'b1;
      end
    end
  end

  // Order for a two-byte unit completed now: a mark updates the swap flag first
  assign le_unit = (byte_order == ORDER_LITTLE) ||
                   ((byte_order == ORDER_AUTO) && (mark ? mark_le : state.swap_bytes));
  assign high    = le_unit ? data_byte : state.held0;

  // Surrogate pair combination, modulo 2^32
  assign hi_unit = unit_of(state.held0, state.held1, le_now);
  assign lo_unit = unit_of(state.held2, data_byte, le_now);
  assign hi_off  = {16'h0000, hi_unit} - HI_BASE;
  assign lo_off  = {16'h0000, lo_unit} - LO_BASE;

  // Advance the held bytes and pick the result
  always_comb begin
    state_next = state;
    have       = 1'b0;
    cp         = 32'h0;
    case (state.held_count)
      CNT_THREE: begin
        cp                       = lo_off + {hi_off[21:0], 10'b0} + PAIR_OFFSET;
        have                     = 1'b1;
        state_next.held_count    = CNT_NONE;
        state_next.pair_expected = 1'b0;
      end
      CNT_TWO: begin
        state_next.held2      = data_byte;
        state_next.held_count = CNT_THREE;
      end
      CNT_ONE: begin
        state_next.at_stream_start = 1'b0;
        if (mark) begin
          state_next.swap_bytes = mark_le;
          state_next.held_count = CNT_NONE;
        end else if ((high > SURR_BELOW) && (high < SURR_ABOVE)) begin
          state_next.held1         = data_byte;
          state_next.held_count    = CNT_TWO;
          state_next.pair_expected = 1'b1;
        end else begin
          cp                    = {16'h0000, unit_of(state.held0, data_byte, le_unit)};
          have                  = 1'b1;
          state_next.held_count = CNT_NONE;
        end
      end
      default: begin
        state_next.held0      = data_byte;
        state_next.held_count = CNT_ONE;
      end
    endcase
    // Drop everything at stream end
    if (last_byte) begin
      state_next = STATE_CLEAR;
    end
  end

  assign result.char_code  = cp;
  assign result.stream_end = last_byte;

endmodule

// ===== rtl/core/utf16d_obuf.sv =====
// Output register with a skid stage for decoded result beats.
module utf16d_obuf import utf16d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_v;
  result_t out_r;
  logic    skid_v;
  result_t skid_r;

  // Move beats into the output register, park one in the skid when stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || !out_stall) begin
      if (skid_v) begin
        out_r  <= skid_r;
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else if (load) begin
        out_r <= load_data;
        out_v <= 1'b1;
      end else begin
        out_v <= 1'b0;
      end
    end else if (load) begin
      skid_r <= load_data;
      skid_v <= 1'b1;
    end
  end

  assign full      = skid_v;
  assign out_valid = out_v;
  assign out_data  = out_r;

endmodule
